>>> rtl/core/prfl_pkg.sv
package prfl_pkg;

   // Field widths of the transactions
   localparam int PAGE_W    = 16;
   localparam int SLOT_W    = 4;
   localparam int FAULT_W   = 16;
   localparam int STAMP_W   = 32;
   localparam int RSP_W     = 40;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int FRAMES_W    = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES = 1'b1;

   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;
   localparam logic                POLICY_FIFO  = 1'b0;
   localparam logic                POLICY_LRU   = 1'b1;

   // Fault counter saturates at all ones
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the request page
      logic decide;     // look up the page and pick a frame
      logic scan_step;  // compare one more stamp for the LRU victim
      logic commit;     // update the table and load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scan;  // LRU fault with more than one frame in use, all occupied
      logic scan_last;  // current scan index is the last frame in use
   } sts_type;

endpackage

>>> rtl/core/prfl_ctrl.sv
module prfl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output prfl_pkg::cmd_type   cmd,
   input  prfl_pkg::sts_type   sts
);
   import prfl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new result when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_WRITE) && out_free);
   assign rsp_tvalid = rsp_valid_ff;

   // Issue datapath commands
   always_comb begin
      cmd.load      = req_tvalid && req_tready;
      cmd.decide    = (state_ff == ST_LOOK);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.commit    = (state_ff == ST_WRITE) && out_free;
   end

   // Sequence one transaction: accept, look up, optional scan, commit
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = sts.need_scan ? ST_SCAN : ST_WRITE;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (cmd.commit) state_in = cmd.load ? ST_LOOK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/prfl_dp.sv
module prfl_dp #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [prfl_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [prfl_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [prfl_pkg::PAGE_W-1:0]            req_page,
   input  prfl_pkg::cmd_type                      cmd,
   output prfl_pkg::sts_type                      sts,
   output logic                                   rsp_hit,
   output logic [prfl_pkg::SLOT_W-1:0]            rsp_slot,
   output logic                                   rsp_evicted_valid,
   output logic [prfl_pkg::PAGE_W-1:0]            rsp_evicted_page,
   output logic [prfl_pkg::FAULT_W-1:0]           rsp_fault_total
);
   import prfl_pkg::*;

   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int EW = (CW > FRAMES_W) ? CW : FRAMES_W;

   // Configuration
   logic                policy_ff;
   logic [FRAMES_W-1:0] frames_ff;

   // Frame table
   logic [PAGE_BITS-1:0] frame_page_ff [MAX_FRAMES];
   logic [STAMP_W-1:0]   last_use_ff   [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] frame_valid_ff, frame_valid_in;
   logic [IW-1:0]        fifo_ptr_ff, fifo_ptr_in;
   logic [STAMP_W-1:0]   access_ff;
   logic [FAULT_W-1:0]   fault_ff, fault_in;

   // Per-transaction working registers
   logic [PAGE_BITS-1:0] page_ff;
   logic                 hit_ff;
   logic [IW-1:0]        sel_ff, sel_in;
   logic [STAMP_W-1:0]   min_ff, min_in;
   logic [IW-1:0]        scan_idx_ff, scan_idx_in;

   // Result register
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_W-1:0]    rsp_ev_page_ff;
   logic [FAULT_W-1:0]   rsp_fault_ff;

   logic [EW-1:0]         f_eff;
   logic [MAX_FRAMES-1:0] match, empty;
   logic                  any_hit, any_empty;
   logic [IW-1:0]         hit_idx, empty_idx, ptr_eff;
   logic [STAMP_W-1:0]    cand;
   logic                  ev_valid;
   logic [PAGE_W-1:0]     ev_page;

   // Clamp the frame count to 1..MAX_FRAMES
   always_comb begin
      if (frames_ff == '0) f_eff = EW'(1);
      else if (EW'(frames_ff) > EW'(MAX_FRAMES)) f_eff = EW'(MAX_FRAMES);
      else f_eff = EW'(frames_ff);
   end

   // Associative compare and empty-frame flags over the frames in use
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = frame_valid_ff[i] && (frame_page_ff[i] == page_ff) && (EW'(i) < f_eff);
         empty[i] = !frame_valid_ff[i] && (EW'(i) < f_eff);
      end
   end

   // Lowest index wins
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) hit_idx = IW'(i);
         if (empty[i]) empty_idx = IW'(i);
      end
   end

   assign any_hit   = |match;
   assign any_empty = |empty;
   assign ptr_eff   = (EW'(fifo_ptr_ff) >= f_eff) ? '0 : fifo_ptr_ff;
   assign cand      = last_use_ff[scan_idx_ff];

   assign sts.need_scan = !any_hit && (policy_ff == POLICY_LRU) && !any_empty
                          && (f_eff > EW'(1));
   assign sts.scan_last = (EW'(scan_idx_ff) == (f_eff - EW'(1)));

   // Pick the frame: hit, FIFO pointer, empty frame, or start the LRU scan
   always_comb begin
      sel_in      = sel_ff;
      min_in      = min_ff;
      scan_idx_in = scan_idx_ff;
      if (cmd.decide) begin
         scan_idx_in = IW'(1);
         min_in      = last_use_ff[0];
         if (any_hit) sel_in = hit_idx;
         else if (policy_ff == POLICY_FIFO) sel_in = ptr_eff;
         else if (any_empty) sel_in = empty_idx;
         else sel_in = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IW'(1);
         if (cand < min_ff) begin
            min_in = cand;
            sel_in = scan_idx_ff;
         end
      end
   end

   // Commit side effects
   always_comb begin
      ev_valid       = !hit_ff && frame_valid_ff[sel_ff];
      ev_page        = ev_valid ? PAGE_W'(frame_page_ff[sel_ff]) : '0;
      frame_valid_in = frame_valid_ff;
      fifo_ptr_in    = fifo_ptr_ff;
      fault_in       = fault_ff;
      if (cmd.commit && !hit_ff) begin
         frame_valid_in[sel_ff] = 1'b1;
         if (fault_ff != FAULT_MAX) fault_in = fault_ff + FAULT_W'(1);
         if (policy_ff == POLICY_FIFO) begin
            fifo_ptr_in = ((EW'(sel_ff) + EW'(1)) >= f_eff) ? '0 : sel_ff + IW'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POLICY_FIFO;
         frames_ff      <= FRAMES_RESET;
         frame_valid_ff <= '0;
         fifo_ptr_ff    <= '0;
         access_ff      <= '0;
         fault_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POLICY: policy_ff <= csr_wdata[0];
               CSR_FRAMES: frames_ff <= csr_wdata[FRAMES_W-1:0];
               default: ;
            endcase
         end
         frame_valid_ff <= frame_valid_in;
         fifo_ptr_ff    <= fifo_ptr_in;
         fault_ff       <= fault_in;
         if (cmd.commit) access_ff <= access_ff + STAMP_W'(1);
      end
   end

   // Payload: table contents, working registers, result register
   always_ff @(posedge clock) begin
      if (cmd.load) page_ff <= PAGE_BITS'(req_page);
      if (cmd.decide) hit_ff <= any_hit;
      sel_ff      <= sel_in;
      min_ff      <= min_in;
      scan_idx_ff <= scan_idx_in;
      if (cmd.commit) begin
         last_use_ff[sel_ff] <= access_ff;
         if (!hit_ff) frame_page_ff[sel_ff] <= page_ff;
         rsp_hit_ff      <= hit_ff;
         rsp_slot_ff     <= SLOT_W'(sel_ff);
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_page_ff  <= ev_page;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

endmodule

>>> rtl/core/page_replacement_fifo_lru_core.sv
// Channel   Dir   Handshake              Payload
// req       in    req_tvalid/req_tready  page
// rsp       out   rsp_tvalid/rsp_tready  hit, slot, evicted_valid, evicted_page, fault_total
// csr       in    csr_we                 csr_index, csr_wdata
//
// A hit, a FIFO fault or a fill of an empty frame passes through a lookup state, then
// a commit state that in steady flow also accepts the next transaction.
// An LRU eviction adds a victim scan between them (F = frames in use), which
// compares one last-use stamp per cycle over frames 1 to F-1.
// Synchronous reset empties every frame at once; there is no clearing pass.
// A result waits in the output register. While idle a new request is still accepted;
// the commit of the following result, and the accept that shares its cycle, wait
// for rsp_tready.
module page_replacement_fifo_lru_core #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [15:0] page
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hit, [4:1] slot, [5] evicted_valid, [21:6] evicted_page,
   // [37:22] fault_total, [39:38] zero
   output logic [prfl_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                               csr_we,
   input  logic [prfl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [prfl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import prfl_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic                hit;
   logic [SLOT_W-1:0]   slot;
   logic                evicted_valid;
   logic [PAGE_W-1:0]   evicted_page;
   logic [FAULT_W-1:0]  fault_total;

   prfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   prfl_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_page          (req_tdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_hit           (hit),
      .rsp_slot          (slot),
      .rsp_evicted_valid (evicted_valid),
      .rsp_evicted_page  (evicted_page),
      .rsp_fault_total   (fault_total)
   );

   // Pack the result transaction
   assign rsp_tdata = {2'b00, fault_total, evicted_page, evicted_valid, slot, hit};

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(hit && evicted_valid))
      else $error("hit reported together with an eviction");

   // No eviction leaves the evicted page at zero
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !evicted_valid) |-> (evicted_page == '0))
      else $error("evicted page nonzero without an eviction");

   // A fault result always counts at least one fault
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit) |-> (fault_total != '0))
      else $error("fault reported with a zero fault total");

   // A commit never overwrites a result that has not been taken
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

endmodule
